/* rtl/ftvd_pkg.sv */
// Package for the FSK tone vote decision block: widths, register indexes,
// class codes and the item structs of the sample and result channels.
// No dependencies.
package ftvd_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int HIST_AW    = $clog2(MAX_WINDOW);
	localparam int VOTE_W     = $clog2(MAX_WINDOW + 1);

	localparam int POWER_W    = 32;
	localparam int RATIO_W    = 16;
	localparam int FRAC_W     = 8;
	localparam int PROD_W     = POWER_W + RATIO_W;
	localparam int WLEN_W     = 7;
	localparam int HOLD_W     = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN      = 2'd0,
		REG_THRESHOLD_RATIO = 2'd1,
		REG_CD_HOLD         = 2'd2
	} cfg_reg_t;

	typedef logic [1:0] class_t;

	localparam class_t CLS_NONE  = 2'd0;
	localparam class_t CLS_MARK  = 2'd1;
	localparam class_t CLS_SPACE = 2'd2;

	typedef struct packed {
		logic [POWER_W-1:0] mark_power;
		logic [POWER_W-1:0] space_power;
	} sample_t;

	typedef struct packed {
		logic   bit_out;
		logic   carrier_on;
		class_t sample_class;
	} result_t;

endpackage

/* rtl/fsk_tone_vote_decision.sv */
// FSK tone vote decision: classifies tone power pairs, keeps a sliding vote
// window in a history RAM and derives the bit and carrier detect.
// Depends on ftvd_pkg.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one pair of
//   mark and space tone powers per item. result channel (result_valid /
//   result_stall / result) returns one item per sample: decided bit, carrier
//   detect and the sample's class. Items come out in order.
//   A sample accepted at the input reaches the outputs through three pipeline
//   registers: products, class, output.
//   Throughput: one item per cycle while result_stall is low. The vote
//   counts update combinationally and the history RAM is read every cycle at
//   the next head address, with a bypass of the entry written in the same
//   cycle, so nothing interlocks. When result_stall is held, the stages behind
//   the output keep taking items until they are full; then sample_stall rises.
//   Configuration: cfg_ready is always high; write only while idle. Writing
//   window_len empties the vote window.
//   Reset (arst_n low) empties the pipeline, the vote window and the runs,
//   sets the held bit to space with noise, and loads the register defaults.
//   No clearing pass: only history entries inside the window are ever read.
module fsk_tone_vote_decision (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  ftvd_pkg::sample_t                   sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ftvd_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ftvd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ftvd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration
	logic [ftvd_pkg::WLEN_W-1:0]  window_len_q;
	logic [ftvd_pkg::RATIO_W-1:0] ratio_q;
	logic [ftvd_pkg::HOLD_W-1:0]  cd_hold_q;
	logic                         cfg_we;

	// pipeline
	logic                          valid_s1;
	logic [ftvd_pkg::POWER_W-1:0]  mark_s1;
	logic [ftvd_pkg::POWER_W-1:0]  space_s1;
	logic [ftvd_pkg::PROD_W-1:0]   mark_r_s1;
	logic [ftvd_pkg::PROD_W-1:0]   space_r_s1;
	logic                          valid_s2;
	ftvd_pkg::class_t              cls_s2;
	ftvd_pkg::class_t              cls_next;
	logic                          result_valid_q;
	ftvd_pkg::result_t             result_q;
	logic                          out_free, s2_free, s1_free, s1_adv, s2_fire, accept;

	// vote state
	logic [ftvd_pkg::VOTE_W-1:0]   fill_q, mark_q, space_q, noise_q;
	logic [ftvd_pkg::HIST_AW-1:0]  head_q;
	logic                          held_bit_q, held_noise_q, carrier_q;
	logic [ftvd_pkg::HOLD_W-1:0]   signal_run_q, noise_run_q;

	// history RAM
	ftvd_pkg::class_t              hist_mem [ftvd_pkg::MAX_WINDOW];
	ftvd_pkg::class_t              rdata_q;
	logic                          byp_q;
	ftvd_pkg::class_t              byp_cls_q;
	logic [ftvd_pkg::HIST_AW-1:0]  rd_addr;

	// next-state values
	logic [ftvd_pkg::VOTE_W-1:0]   len;
	logic                          full;
	ftvd_pkg::class_t              old_cls;
	logic [ftvd_pkg::VOTE_W-1:0]   mk1, sp1, nz1, mk2, sp2, nz2, fill1, fill2;
	logic [ftvd_pkg::HIST_AW-1:0]  head1, slot;
	logic [ftvd_pkg::VOTE_W:0]     slot_sum;
	logic                          hb, hn, bit_nx, cf;
	logic [ftvd_pkg::HOLD_W-1:0]   srun, nrun;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	assign out_free     = !result_valid_q || !result_stall;
	assign s2_fire      = valid_s2 && out_free;
	assign s2_free      = !valid_s2 || out_free;
	assign s1_adv       = valid_s1 && s2_free;
	assign s1_free      = !valid_s1 || s2_free;
	assign accept       = sample_valid && s1_free;
	assign sample_stall = !s1_free;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= ftvd_pkg::WLEN_W'(16);
			ratio_q      <= ftvd_pkg::RATIO_W'(512);
			cd_hold_q    <= ftvd_pkg::HOLD_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				ftvd_pkg::REG_WINDOW_LEN:      window_len_q <= cfg_data[ftvd_pkg::WLEN_W-1:0];
				ftvd_pkg::REG_THRESHOLD_RATIO: ratio_q      <= cfg_data[ftvd_pkg::RATIO_W-1:0];
				ftvd_pkg::REG_CD_HOLD:         cd_hold_q    <= cfg_data[ftvd_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline valids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s1_free)  valid_s1       <= sample_valid;
			if (s2_free)  valid_s2       <= valid_s1;
			if (out_free) result_valid_q <= valid_s2;
		end
	end

	// Stage 1: ratio products
	always_ff @(posedge clk) begin
		if (accept) begin
			mark_s1    <= sample.mark_power;
			space_s1   <= sample.space_power;
			mark_r_s1  <= ftvd_pkg::PROD_W'(sample.mark_power) * ftvd_pkg::PROD_W'(ratio_q);
			space_r_s1 <= ftvd_pkg::PROD_W'(sample.space_power) * ftvd_pkg::PROD_W'(ratio_q);
		end
	end

	// Stage 2: classification (mark test first)
	always_comb begin
		if (mark_s1 == '0 && space_s1 == '0)
			cls_next = ftvd_pkg::CLS_NONE;
		else if ({mark_s1, ftvd_pkg::FRAC_W'(0)} >= space_r_s1)
			cls_next = ftvd_pkg::CLS_MARK;
		else if (mark_r_s1 <= {space_s1, ftvd_pkg::FRAC_W'(0)})
			cls_next = ftvd_pkg::CLS_SPACE;
		else
			cls_next = ftvd_pkg::CLS_NONE;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) cls_s2 <= cls_next;
	end

	// Vote update
	always_comb begin
		if (window_len_q == '0)
			len = ftvd_pkg::VOTE_W'(1);
		else if (int'(window_len_q) > ftvd_pkg::MAX_WINDOW)
			len = ftvd_pkg::VOTE_W'(ftvd_pkg::MAX_WINDOW);
		else
			len = ftvd_pkg::VOTE_W'(window_len_q);

		full    = fill_q >= len;
		old_cls = byp_q ? byp_cls_q : rdata_q;
		mk1     = mark_q;
		sp1     = space_q;
		nz1     = noise_q;
		head1   = head_q;
		fill1   = fill_q;
		if (full) begin
			case (old_cls)
				ftvd_pkg::CLS_MARK:  if (mk1 != '0) mk1 = mk1 - 1'b1;
				ftvd_pkg::CLS_SPACE: if (sp1 != '0) sp1 = sp1 - 1'b1;
				default:             if (nz1 != '0) nz1 = nz1 - 1'b1;
			endcase
			if (int'(head_q) == ftvd_pkg::MAX_WINDOW - 1)
				head1 = '0;
			else
				head1 = head_q + 1'b1;
			fill1 = fill_q - 1'b1;
		end

		mk2 = mk1;
		sp2 = sp1;
		nz2 = nz1;
		case (cls_s2)
			ftvd_pkg::CLS_MARK:  if (mk1 < len) mk2 = mk1 + 1'b1;
			ftvd_pkg::CLS_SPACE: if (sp1 < len) sp2 = sp1 + 1'b1;
			default:             if (nz1 < len) nz2 = nz1 + 1'b1;
		endcase

		slot_sum = (ftvd_pkg::VOTE_W+1)'(head1) + (ftvd_pkg::VOTE_W+1)'(fill1);
		if (int'(slot_sum) >= ftvd_pkg::MAX_WINDOW)
			slot = ftvd_pkg::HIST_AW'(slot_sum - (ftvd_pkg::VOTE_W+1)'(ftvd_pkg::MAX_WINDOW));
		else
			slot = ftvd_pkg::HIST_AW'(slot_sum);
		fill2 = fill1 + 1'b1;

		hb = held_bit_q;
		hn = held_noise_q;
		if (mk2 > nz2 && mk2 > sp2) begin
			hb     = 1'b1;
			hn     = 1'b0;
			bit_nx = 1'b1;
		end else if (sp2 > nz2 && sp2 > mk2) begin
			hb     = 1'b0;
			hn     = 1'b0;
			bit_nx = 1'b0;
		end else if (nz2 > mk2 && nz2 > sp2) begin
			hn     = 1'b1;
			bit_nx = !held_bit_q;
		end else begin
			bit_nx = held_noise_q ? !held_bit_q : held_bit_q;
		end

		// carrier detect runs follow the updated noise flag
		srun = signal_run_q;
		nrun = noise_run_q;
		cf   = carrier_q;
		if (!hn) begin
			if (signal_run_q < cd_hold_q) begin
				nrun = '0;
				srun = signal_run_q + 1'b1;
			end else begin
				cf = 1'b1;
			end
		end else begin
			if (noise_run_q < cd_hold_q) begin
				srun = '0;
				nrun = noise_run_q + 1'b1;
			end else begin
				cf = 1'b0;
			end
		end
	end

	assign rd_addr = s2_fire ? head1 : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			head_q       <= '0;
			mark_q       <= '0;
			space_q      <= '0;
			noise_q      <= '0;
			held_bit_q   <= 1'b0;
			held_noise_q <= 1'b1;
			signal_run_q <= '0;
			noise_run_q  <= '0;
			carrier_q    <= 1'b0;
			byp_q        <= 1'b0;
		end else begin
			byp_q <= s2_fire && (slot == rd_addr);
			if (cfg_we && cfg_index == ftvd_pkg::REG_WINDOW_LEN) begin
				fill_q  <= '0;
				head_q  <= '0;
				mark_q  <= '0;
				space_q <= '0;
				noise_q <= '0;
			end else if (s2_fire) begin
				fill_q       <= fill2;
				head_q       <= head1;
				mark_q       <= mk2;
				space_q      <= sp2;
				noise_q      <= nz2;
				held_bit_q   <= hb;
				held_noise_q <= hn;
				signal_run_q <= srun;
				noise_run_q  <= nrun;
				carrier_q    <= cf;
			end
		end
	end

	// History RAM: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (s2_fire) hist_mem[slot] <= cls_s2;
		rdata_q   <= hist_mem[rd_addr];
		byp_cls_q <= cls_s2;
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			result_q.bit_out      <= bit_nx;
			result_q.carrier_on   <= cf;
			result_q.sample_class <= cls_s2;
		end
	end

`ifndef SYNTHESIS
	// every class in the window is counted exactly once
	a_votes_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(ftvd_pkg::VOTE_W+2)'(mark_q) + (ftvd_pkg::VOTE_W+2)'(space_q)
			+ (ftvd_pkg::VOTE_W+2)'(noise_q) == (ftvd_pkg::VOTE_W+2)'(fill_q))
		else $error("vote counts do not match window fill");

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len)
		else $error("window fill beyond window length");

	a_carrier_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(carrier_q) |-> !held_noise_q)
		else $error("carrier detect set while noise is held");

	a_head_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s2_fire) && !$past(cfg_we) |-> $stable(head_q))
		else $error("window head moved without an item");
`endif

endmodule
